// ----- hw/rtl/vpa_pkg.sv -----
// Shared types and constants for the polyphonic voice allocator.
`default_nettype none

package vpa_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;
  localparam int SLOT_NOTE_W = 8;
  localparam int VOICE_SLOT_W = 3;

  localparam logic MODE_NOTE_ON = 1'b0;
  localparam logic MODE_NOTE_OFF = 1'b1;

  localparam logic [SLOT_NOTE_W-1:0] EMPTY_NOTE = 8'hFF;

  typedef struct packed {
    logic              mode;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;
  } vpa_in_t;

  typedef struct packed {
    logic [VOICE_SLOT_W-1:0] voice_slot;
    logic                    slot_hit;
  } vpa_out_t;

  typedef struct packed {
    logic              en;
    logic              release_slot;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } vpa_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vpa_slot_bank.sv -----
// Voice slot storage with per-slot free and note-match flags.
`default_nettype none

module vpa_slot_bank #(
  parameter int VOICES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [vpa_pkg::NOTE_W-1:0] lookup_note,
  input  wire vpa_pkg::vpa_wr_t           wr,
  input  wire logic [VOICES-1:0]          wr_sel,
  output logic [VOICES-1:0]               free_vec,
  output logic [VOICES-1:0]               match_vec
);
  import vpa_pkg::*;

  logic [SLOT_NOTE_W-1:0] slot_note [VOICES];
  logic [VEL_W-1:0]       slot_velocity [VOICES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        slot_note[i] <= EMPTY_NOTE;
        slot_velocity[i] <= '0;
      end
    end else if (wr.en) begin
      for (int i = 0; i < VOICES; i++) begin
        if (wr_sel[i]) begin
          if (wr.release_slot) begin
            slot_note[i] <= EMPTY_NOTE;
            slot_velocity[i] <= '0;
          end else begin
            slot_note[i] <= {1'b0, wr.note};
            slot_velocity[i] <= wr.vel;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      free_vec[i] = (slot_velocity[i] == '0);
      match_vec[i] = (slot_velocity[i] != '0) && (slot_note[i] == {1'b0, lookup_note});
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/poly_voice_allocator.sv -----
// Polyphonic voice allocator: lowest free slot on note-on, lowest match on note-off.
//
// Events enter on the event channel (event_valid/event_ready/event_data) and
// each produces exactly one transaction on the result channel
// (result_valid/result_ready/result_data). A note-on with nonzero velocity
// takes the lowest free slot; a note-off frees the lowest busy slot holding
// that note. Ignored events report slot_hit 0 and voice_slot 0.
// An accepted event is held in an input register, resolved against the slot
// table by a priority pick, and its result is loaded into the result register
// once that register is empty or the receiver takes the result it holds.
// The slot table is updated in the same cycle the result is registered, so
// the next event sees it.
// One event per cycle is sustained while the receiver keeps up; the rate is
// set by the combinational slot search and the table update made per result.
// Reset clears every slot to free with the empty note marker and drops both
// valid flags; no clearing pass is needed. When the receiver stalls, the
// result register holds, the input register fills, and event_ready falls.
`default_nettype none

module poly_voice_allocator #(
  parameter int VOICES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              event_valid,
  output logic                   event_ready,
  input  wire vpa_pkg::vpa_in_t  event_data,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output vpa_pkg::vpa_out_t      result_data
);
  import vpa_pkg::*;

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic              pend_valid;
  vpa_in_t           pend_item;
  logic              advance;
  logic [VOICES-1:0] free_vec;
  logic [VOICES-1:0] match_vec;
  logic [VOICES-1:0] cand;
  logic [VOICES-1:0] pick;
  logic              hit;
  logic [IDX_W-1:0]  pick_idx;
  logic [IDX_W+VOICE_SLOT_W-1:0] idx_ext;
  vpa_wr_t           wr;
  vpa_out_t          result_next;

  assign advance = pend_valid && (!result_valid || result_ready);
  assign event_ready = !pend_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (event_ready) begin
      pend_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_valid && event_ready) begin
      pend_item <= event_data;
    end
  end

  vpa_slot_bank #(.VOICES(VOICES)) u_bank (
    .clk        (clk),
    .rst        (rst),
    .lookup_note(pend_item.note_number),
    .wr         (wr),
    .wr_sel     (pick),
    .free_vec   (free_vec),
    .match_vec  (match_vec)
  );

  always_comb begin
    if (pend_item.mode == MODE_NOTE_ON) begin
      cand = (pend_item.note_velocity != '0) ? free_vec : '0;
    end else begin
      cand = match_vec;
    end
    pick = cand & (~cand + {{(VOICES-1){1'b0}}, 1'b1});
    hit = |cand;
    pick_idx = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
    idx_ext = {{VOICE_SLOT_W{1'b0}}, pick_idx};
    wr.en = advance && hit;
    wr.release_slot = (pend_item.mode == MODE_NOTE_OFF);
    wr.note = pend_item.note_number;
    wr.vel = pend_item.note_velocity;
    result_next.voice_slot = hit ? idx_ext[VOICE_SLOT_W-1:0] : '0;
    result_next.slot_hit = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vpa_checker.sv -----
// Port-level checks for the voice allocator, bound to the top level.
`default_nettype none

module vpa_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              event_valid,
  input wire logic              event_ready,
  input wire vpa_pkg::vpa_in_t  event_data,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire vpa_pkg::vpa_out_t result_data
);
  import vpa_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid && event_ready)
    else $error("Block not idle after reset.");

  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_data))
    else $error("Stalled event transaction changed.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !event_ready |-> result_valid)
    else $error("Event channel stalled with no result pending.");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.slot_hit |-> result_data.voice_slot == '0)
    else $error("Ignored event reports a nonzero slot.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("Stalled result transaction changed.");

endmodule

bind poly_voice_allocator vpa_checker u_vpa_checker (
  .clk         (clk),
  .rst         (rst),
  .event_valid (event_valid),
  .event_ready (event_ready),
  .event_data  (event_data),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result_data (result_data)
);

`default_nettype wire

// ----- tb/poly_voice_allocator_chk.sv -----
// Checker for the voice allocator: slot table predictor and result scoreboard.
module poly_voice_allocator_chk #(
  parameter int VOICES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              event_valid,
  input  logic              event_ready,
  input  vpa_pkg::vpa_in_t  event_data,
  input  logic              result_valid,
  input  logic              result_ready,
  input  vpa_pkg::vpa_out_t result_data,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                hits
);
  import vpa_pkg::*;

  logic [SLOT_NOTE_W-1:0] voice_note [VOICES];
  logic [VEL_W-1:0]       voice_vel  [VOICES];
  vpa_out_t               expected_slots [$];
  int                     fail_tally = 0;
  int                     check_tally = 0;
  int                     hit_tally = 0;

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    hits = 0;
  end

  function automatic void clear_voices();
    for (int i = 0; i < VOICES; i++) begin
      voice_note[i] = EMPTY_NOTE;
      voice_vel[i] = '0;
    end
  endfunction

  // Applies one event to the predicted slot table and returns the slot it touches.
  function automatic vpa_out_t allocate_voice(vpa_in_t ev);
    vpa_out_t res;
    res = '0;
    if (ev.mode == MODE_NOTE_ON) begin
      if (ev.note_velocity != '0) begin
        for (int i = 0; i < VOICES; i++) begin
          if (!res.slot_hit && voice_vel[i] == '0) begin
            voice_note[i] = {1'b0, ev.note_number};
            voice_vel[i] = ev.note_velocity;
            res.voice_slot = VOICE_SLOT_W'(i);
            res.slot_hit = 1'b1;
          end
        end
      end
    end else begin
      for (int i = 0; i < VOICES; i++) begin
        if (!res.slot_hit && voice_vel[i] != '0 &&
            voice_note[i] == {1'b0, ev.note_number}) begin
          voice_vel[i] = '0;
          voice_note[i] = EMPTY_NOTE;
          res.voice_slot = VOICE_SLOT_W'(i);
          res.slot_hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    vpa_out_t want;
    if (rst) begin
      clear_voices();
      expected_slots.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_slots.size() == 0) begin
          fail_tally++;
          $display("%0t unexpected result: expected none, actual slot %0d hit %0b",
                   $time, result_data.voice_slot, result_data.slot_hit);
        end else begin
          want = expected_slots.pop_front();
          check_tally++;
          if (result_data.slot_hit) hit_tally++;
          if (result_data.voice_slot !== want.voice_slot ||
              result_data.slot_hit !== want.slot_hit) begin
            fail_tally++;
            $display("%0t result mismatch: expected slot %0d hit %0b, actual slot %0d hit %0b",
                     $time, want.voice_slot, want.slot_hit,
                     result_data.voice_slot, result_data.slot_hit);
          end
        end
      end
      if (event_valid && event_ready) expected_slots.push_back(allocate_voice(event_data));
    end
    errors <= fail_tally;
    pending <= expected_slots.size();
    checked <= check_tally;
    hits <= hit_tally;
  end

endmodule

// ----- tb/poly_voice_allocator_tb.sv -----
// Testbench top for the voice allocator: stimulus, flow control and verdict.
module poly_voice_allocator_tb;
  import vpa_pkg::*;

  localparam int VOICES = 8;
  localparam int RANDOM_EVENTS = 1325;
  localparam int QUIET_LIMIT = 1000;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_LONG} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     event_valid = 1'b0;
  logic     event_ready;
  vpa_in_t  event_data = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  vpa_out_t result_data;

  int       chk_errors;
  int       chk_pending;
  int       chk_checked;
  int       chk_hits;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_stall = 0;
  logic     tx_gappy = 1'b1;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  int       sent_events = 0;
  logic [NOTE_W-1:0] held_notes [$];

  always #5 clk = ~clk;

  poly_voice_allocator #(.VOICES(VOICES)) uut (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_data  (event_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

  poly_voice_allocator_chk #(.VOICES(VOICES)) chk (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_data  (event_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data),
    .errors      (chk_errors),
    .pending     (chk_pending),
    .checked     (chk_checked),
    .hits        (chk_hits)
  );

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      result_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      case (rx_mode)
        RX_FREE: result_ready <= 1'b1;
        RX_CHOPPY: result_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_stall <= $urandom_range(5, 40);
            result_ready <= 1'b0;
          end else begin
            result_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (event_valid && event_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic vpa_in_t midi_event(logic mode, int note, int vel);
    vpa_in_t ev;
    ev.mode = mode;
    ev.note_number = NOTE_W'(note);
    ev.note_velocity = VEL_W'(vel);
    return ev;
  endfunction

  // Keeps the set of sounding notes so that note-offs can target them.
  function automatic void track_notes(vpa_in_t ev);
    int idx;
    idx = -1;
    if (ev.mode == MODE_NOTE_ON) begin
      if (ev.note_velocity != '0 && held_notes.size() < VOICES)
        held_notes.push_back(ev.note_number);
    end else begin
      for (int i = 0; i < held_notes.size(); i++)
        if (idx < 0 && held_notes[i] == ev.note_number) idx = i;
      if (idx >= 0) held_notes.delete(idx);
    end
  endfunction

  task automatic send_event(input vpa_in_t ev);
    int gap;
    if (burst_left == 0) begin
      if (tx_gappy) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
        event_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    event_valid <= 1'b1;
    event_data <= ev;
    track_notes(ev);
    sent_events++;
    @(posedge clk);
    while (!event_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    event_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  function automatic vpa_in_t random_event();
    int pick;
    int on_share;
    pick = $urandom_range(0, 99);
    on_share = (held_notes.size() == VOICES) ? 20 : 45;
    if (pick < on_share) begin
      return midi_event(MODE_NOTE_ON,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(60, 63)
                                                    : $urandom_range(0, 127),
                        $urandom_range(1, 127));
    end else if (pick < 78 && held_notes.size() != 0) begin
      return midi_event(MODE_NOTE_OFF, held_notes[$urandom_range(0, held_notes.size() - 1)],
                        $urandom_range(0, 127));
    end else if (pick < 88) begin
      return midi_event(MODE_NOTE_OFF, $urandom_range(0, 127), $urandom_range(0, 127));
    end else if (pick < 94) begin
      return midi_event(MODE_NOTE_ON, $urandom_range(0, 127), 0);
    end
    return vpa_in_t'(($bits(vpa_in_t))'($urandom));
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rx_mode = RX_CHOPPY;
    send_event(midi_event(MODE_NOTE_ON, 0, 127));
    send_event(midi_event(MODE_NOTE_ON, 127, 1));
    send_event(midi_event(MODE_NOTE_ON, 5, 0));
    send_event(midi_event(MODE_NOTE_OFF, 64, 0));
    send_event(midi_event(MODE_NOTE_OFF, 127, 0));
    // The freed slot now carries the empty marker and must not match again.
    send_event(midi_event(MODE_NOTE_OFF, 127, 127));
    send_event(midi_event(MODE_NOTE_ON, 60, 85));
    send_event(midi_event(MODE_NOTE_ON, 60, 42));
    send_event(midi_event(MODE_NOTE_ON, 61, 100));
    send_event(midi_event(MODE_NOTE_ON, 62, 7));
    send_event(midi_event(MODE_NOTE_ON, 63, 64));
    send_event(midi_event(MODE_NOTE_ON, 64, 120));
    send_event(midi_event(MODE_NOTE_ON, 65, 33));
    send_event(midi_event(MODE_NOTE_ON, 70, 100));
    send_event(midi_event(MODE_NOTE_OFF, 60, 127));
    send_event(midi_event(MODE_NOTE_OFF, 60, 0));
    send_event(midi_event(MODE_NOTE_OFF, 60, 0));
    send_event(midi_event(MODE_NOTE_ON, 99, 64));
    send_event(midi_event(MODE_NOTE_OFF, 0, 0));
    send_event(midi_event(MODE_NOTE_OFF, 99, 0));
    send_event(midi_event(MODE_NOTE_OFF, 61, 0));
    send_event(midi_event(MODE_NOTE_OFF, 62, 0));
    send_event(midi_event(MODE_NOTE_OFF, 63, 0));
    send_event(midi_event(MODE_NOTE_OFF, 64, 0));
    send_event(midi_event(MODE_NOTE_OFF, 65, 0));
    drain_results();

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 450 == 0) begin
        drain_results();
        case (n / 450)
          0: begin rx_mode = RX_CHOPPY; tx_gappy = 1'b1; end
          1: begin rx_mode = RX_FREE; tx_gappy = 1'b0; end
          default: begin rx_mode = RX_LONG; tx_gappy = 1'b1; end
        endcase
      end
      send_event(random_event());
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("sent %0d note events, checked %0d results, %0d of them assigned or freed a slot",
             sent_events, chk_checked, chk_hits);
    $display("directed slot-table corner cases plus random play under three flow-control mixes");
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
